>>> hdl/iir_direct_form_one_core_defines.svh
// iir_direct_form_one_core_defines.svh: assertion macros for the filter checker
// depends on nothing; taken in by the checker with `include
`ifndef IIR_DIRECT_FORM_ONE_CORE_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_CORE_DEFINES_SVH

// concurrent assertion on a clock, off while reset is low
`define IIR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define IIR_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/iirdf1_pkg.sv
// iirdf1_pkg: widths, register indexes and shared types of the direct-form-I filter
// depends on nothing
package iirdf1_pkg;

	localparam int COEF_BITS        = 18;
	localparam int FRAC_BITS        = 14;
	localparam int ACC_BITS         = 48;
	localparam int NUM_REGS         = 7;
	localparam int REG_IDX_BITS     = 3;
	localparam int ADDR_BITS        = 5;
	localparam int APB_DATA_BITS    = 32;
	localparam int FILTER_ORDER_DEF = 3;
	localparam int SAMPLE_BITS_DEF  = 16;
	// highest b index and highest a index that have a coefficient register
	localparam int MAX_COEF_TAP     = 3;

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_B3 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_A3 = 3'd6;

	localparam logic signed [COEF_BITS-1:0] B0_RESET = 18'sd16384;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// issue control from the sequencer to the shared mac
	typedef struct packed {
		logic valid;   // an operand pair is presented this cycle
		logic first;   // first tap of the sample: load instead of add
		logic sub;     // feedback tap: subtract the product
	} mac_ctrl_t;

endpackage

>>> hdl/iir_direct_form_one_core.sv
// iir_direct_form_one_core: direct-form-I iir filter, one shared mac under a tap sequencer
// depends on iirdf1_pkg, iirdf1_regs, iirdf1_mac
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata: sample_in
//  m_*       out        m_tvalid / m_tready    m_tdata: sample_out
//  apb       in         psel, penable, pready  b0..b3, a1..a3 at 4*index
//
// a word goes through an accept step, one mac issue per tap, a drain step for the
// accumulator and a round and saturate step, in that order; the taps take turns
// on the single multiplier that serves every tap.
// s_tready is high only while the sequencer is idle; a finished word waits in the
// output register, and the round step holds while that register is still full.
// reset clears the coefficients to b0 = 1.0, the rest zero, and both histories to zero.
module iir_direct_form_one_core #(
	parameter int FILTER_ORDER = iirdf1_pkg::FILTER_ORDER_DEF,
	parameter int SAMPLE_BITS  = iirdf1_pkg::SAMPLE_BITS_DEF,
	localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// bits [SAMPLE_BITS-1:0] sample_in, rest unused
	input  logic [TDATA_BITS-1:0]                s_tdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// bits [SAMPLE_BITS-1:0] sample_out, rest zero
	output logic [TDATA_BITS-1:0]                m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [iirdf1_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [iirdf1_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [iirdf1_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                 pready
);
	import iirdf1_pkg::*;

	localparam int NUM_TAPS = 2 * FILTER_ORDER + 1;
	localparam int TAP_W    = $clog2(NUM_TAPS);
	localparam int RND_W    = ACC_BITS + 1 - FRAC_BITS;
	localparam logic signed [RND_W-1:0] SAT_MAX =
		RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_MIN =
		RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam logic signed [ACC_BITS:0] RND_HALF =
		(ACC_BITS + 1)'(64'sd1 <<< (FRAC_BITS - 1));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	state_t                        state_q;
	logic [TAP_W-1:0]              tap_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] xh_q [FILTER_ORDER];
	logic signed [SAMPLE_BITS-1:0] yh_q [FILTER_ORDER];
	logic [SAMPLE_BITS-1:0]        out_q;
	logic                          out_valid_q;

	coef_t                         coef [NUM_REGS];
	mac_ctrl_t                     mac_ctrl;
	coef_t                         op_coef;
	logic signed [SAMPLE_BITS-1:0] op_sample;
	logic signed [ACC_BITS-1:0]    acc;
	logic signed [ACC_BITS:0]      acc_rnd;
	logic signed [RND_W-1:0]       rnd;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          out_free;

	iirdf1_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	iirdf1_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (op_coef),
		.sample (op_sample),
		.acc    (acc)
	);

	// issue control: taps 0..order are feed-forward, the rest feedback
	always_comb begin
		mac_ctrl.valid = (state_q == ST_RUN);
		mac_ctrl.first = (tap_q == '0);
		mac_ctrl.sub   = (tap_q > TAP_W'(FILTER_ORDER));
	end

	// operand select; feed-forward taps above b3 and feedback taps above a3 have no coefficient and use zero
	always_comb begin
		op_coef   = '0;
		op_sample = x_q;
		for (int i = 0; i < FILTER_ORDER; i++) begin
			if (tap_q == TAP_W'(i + 1)) begin
				op_sample = xh_q[i];
			end
			if (tap_q == TAP_W'(FILTER_ORDER + 1 + i)) begin
				op_sample = yh_q[i];
			end
		end
		for (int i = 0; i <= MAX_COEF_TAP; i++) begin
			if ((i <= FILTER_ORDER) && (tap_q == TAP_W'(i))) begin
				op_coef = coef[REG_B0 + REG_IDX_BITS'(i)];
			end
		end
		for (int i = 1; i <= MAX_COEF_TAP; i++) begin
			if ((i <= FILTER_ORDER) && (tap_q == TAP_W'(FILTER_ORDER + i))) begin
				op_coef = coef[REG_A1 + REG_IDX_BITS'(i - 1)];
			end
		end
	end

	// round half up, then saturate to the sample range
	assign acc_rnd = (ACC_BITS + 1)'(acc) + RND_HALF;
	assign rnd     = $signed(acc_rnd[ACC_BITS:FRAC_BITS]);

	always_comb begin
		if (rnd > SAT_MAX) begin
			y_sat = SAMPLE_BITS'(SAT_MAX);
		end else if (rnd < SAT_MIN) begin
			y_sat = SAMPLE_BITS'(SAT_MIN);
		end else begin
			y_sat = rnd[SAMPLE_BITS-1:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// sequencer, histories and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FILTER_ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			// output word taken; a round step refilling the register sets valid itself
			if (out_valid_q && m_tready && (state_q != ST_ROUND)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (s_tvalid) begin
						x_q     <= $signed(s_tdata[SAMPLE_BITS-1:0]);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_q == TAP_W'(NUM_TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_free) begin
						out_q       <= y_sat;
						out_valid_q <= 1'b1;
						xh_q[0]     <= x_q;
						yh_q[0]     <= y_sat;
						for (int i = 1; i < FILTER_ORDER; i++) begin
							xh_q[i] <= xh_q[i-1];
							yh_q[i] <= yh_q[i-1];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_BITS'(out_q);

endmodule

>>> hdl/iirdf1_regs.sv
// iirdf1_regs: apb coefficient register file, seven signed q3.14 registers
// depends on iirdf1_pkg
module iirdf1_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [iirdf1_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [iirdf1_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [iirdf1_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                   pready,
	output iirdf1_pkg::coef_t                      coef [iirdf1_pkg::NUM_REGS]
);
	import iirdf1_pkg::*;

	coef_t                   coef_q [NUM_REGS];
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr_en;

	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register write, index seven and up is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[REG_B0] <= B0_RESET;
		end else if (wr_en && (idx < REG_IDX_BITS'(NUM_REGS))) begin
			coef_q[idx] <= coef_t'(pwdata[COEF_BITS-1:0]);
		end
	end

	// read back, sign extended
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3:
				prdata = APB_DATA_BITS'(coef_q[idx]);
			default: prdata = '0;
		endcase
	end

	assign coef = coef_q;

endmodule

>>> hdl/iirdf1_mac.sv
// iirdf1_mac: shared multiply-accumulate unit, product register then 48-bit accumulator
// depends on iirdf1_pkg
module iirdf1_mac #(
	parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iirdf1_pkg::mac_ctrl_t                  ctrl,
	input  iirdf1_pkg::coef_t                      coef,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	output logic signed [iirdf1_pkg::ACC_BITS-1:0] acc
);
	import iirdf1_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

	logic signed [PROD_BITS-1:0] prod_s1;
	mac_ctrl_t                   ctrl_s1;
	logic signed [ACC_BITS-1:0]  prod_ext;
	logic signed [ACC_BITS-1:0]  addend;
	logic signed [ACC_BITS-1:0]  acc_q;

	// stage 1: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.valid) begin
			prod_s1 <= coef * sample;
		end
	end

	// product is sign extended, or truncated if wider, to the accumulator width
	assign prod_ext = ACC_BITS'(prod_s1);
	assign addend   = ctrl_s1.first ? '0 : acc_q;

	// stage 2: accumulate, modulo 2^48
	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			acc_q <= ctrl_s1.sub ? (addend - prod_ext) : (addend + prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

>>> hdl/iirdf1_checker.sv
// iirdf1_checker: port-level assertions for the filter core, bound to the top level
// depends on iir_direct_form_one_core_defines.svh and iir_direct_form_one_core
`include "iir_direct_form_one_core_defines.svh"

module iirdf1_checker #(
	parameter int TDATA_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [TDATA_BITS-1:0] m_tdata,
	input logic                  pready
);

	// a stalled output word holds
	`IIR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

	// one word at a time: no accept in the cycle after an accept
	`IIR_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted while busy")

	// a result never appears right after its input was taken
	`IIR_ASSERT(a_no_early_result, clk, arst_n, !($rose(m_tvalid) && $past(s_tvalid && s_tready)), "result too early after accept")

	// configuration port never waits
	`IIR_ASSERT(a_pready_high, clk, arst_n, pready, "pready dropped")

endmodule

bind iir_direct_form_one_core iirdf1_checker #(
	.TDATA_BITS (TDATA_BITS)
) u_iirdf1_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
